### rtl/rbv_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the record blob validator.
// No dependencies.
package rbv_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int ID_BYTES     = 16;
    localparam int SYMBOL_BYTES = 16;
    localparam int NAME_BYTES   = 32;

    localparam int HEADER_LEN = 6;
    localparam int ENTRY_LEN  = ID_BYTES + SYMBOL_BYTES + NAME_BYTES + 9;
    localparam int STR1_END   = ID_BYTES;
    localparam int STR2_END   = STR1_END + SYMBOL_BYTES;
    localparam int STR3_END   = STR2_END + NAME_BYTES;

    localparam int PE_W  = $clog2(ENTRY_LEN);
    localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
    localparam int POS_W = 12;
    localparam logic [POS_W-1:0] POS_SAT = '1;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXP_VERSION = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b1;
    localparam logic [7:0] RST_EXP_VERSION = 8'd1;
    localparam logic [4:0] RST_MAX_ENTRIES = 5'd16;

    typedef enum logic [3:0] {
        TAG_HEADER  = 4'd0,
        TAG_ID      = 4'd1,
        TAG_SYMBOL  = 4'd2,
        TAG_NAME    = 4'd3,
        TAG_SOURCE  = 4'd4,
        TAG_KIND    = 4'd5,
        TAG_BASIS   = 4'd6,
        TAG_CADENCE = 4'd7,
        TAG_STALE   = 4'd8,
        TAG_EXCESS  = 4'd9
    } t_tag;

    typedef enum logic [3:0] {
        ST_OK      = 4'd0,
        ST_SHORT   = 4'd1,
        ST_VERSION = 4'd2,
        ST_COUNT   = 4'd3,
        ST_LENGTH  = 4'd4,
        ST_CRC     = 4'd5,
        ST_SOURCE  = 4'd6,
        ST_KIND    = 4'd7,
        ST_BASIS   = 4'd8
    } t_status;

    typedef struct packed {
        logic [3:0]  entry_index;
        t_tag        field_tag;
        logic [7:0]  byte_out;
        logic        field_end;
        logic [31:0] number_value;
        logic        blob_done;
        t_status     status;
        logic [4:0]  entry_count;
    } t_result;

endpackage

### rtl/rbv_blob_if.sv
`timescale 1ns / 1ps
// Input channel: one blob byte per word with an end-of-blob flag.
// No dependencies.
interface rbv_blob_if;
    logic       valid;
    logic       ready;
    logic [7:0] blob_byte;
    logic       last_byte;

    modport source (output valid, output blob_byte, output last_byte, input ready);
    modport sink   (input valid, input blob_byte, input last_byte, output ready);
endinterface

### rtl/rbv_rec_if.sv
`timescale 1ns / 1ps
// Output channel: tagged byte echo with the final blob status.
// No dependencies.
interface rbv_rec_if;
    logic        valid;
    logic        ready;
    logic [3:0]  entry_index;
    logic [3:0]  field_tag;
    logic [7:0]  byte_out;
    logic        field_end;
    logic [31:0] number_value;
    logic        blob_done;
    logic [3:0]  status;
    logic [4:0]  entry_count;

    modport source (output valid, output entry_index, output field_tag, output byte_out,
                    output field_end, output number_value, output blob_done,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input entry_index, input field_tag, input byte_out,
                    input field_end, input number_value, input blob_done,
                    input status, input entry_count, output ready);
endinterface

### rtl/rbv_crc_byte.sv
`timescale 1ns / 1ps
// Byte-wide update of a reflected CRC-32.
// Depends on rbv_pkg.
module rbv_crc_byte
    import rbv_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

### rtl/rbv_parser.sv
`timescale 1ns / 1ps
// Blob parse state, field tagging, code checks and final status.
// Depends on rbv_pkg and rbv_crc_byte.
module rbv_parser
    import rbv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [7:0]  i_exp_version,
    input  logic [4:0]  i_max_entries,
    output t_result     o_res
);

    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_stored_crc, n_stored_crc;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [PE_W-1:0]  r_pe, n_pe;
    logic [ENT_W-1:0] r_entry, n_entry;
    logic [7:0]       r_count, n_count;
    logic [7:0]       r_version, n_version;
    t_status          r_code_err, n_code_err;
    logic [31:0]      r_num, n_num;

    logic [31:0] crc_upd;

    rbv_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_upd)
    );

    always_comb begin
        logic        in_header;
        logic [7:0]  limit;
        logic [PE_W:0] pe_inc;
        logic [1:0]  k;
        logic [31:0] num_base;
        logic [15:0] exp_len;
        logic [15:0] got_len;
        t_result     res;

        n_crc        = r_crc;
        n_stored_crc = r_stored_crc;
        n_pos        = (r_pos < POS_SAT) ? r_pos + 1'b1 : r_pos;
        n_pe         = r_pe;
        n_entry      = r_entry;
        n_count      = r_count;
        n_version    = r_version;
        n_code_err   = r_code_err;
        n_num        = r_num;

        res              = '0;
        res.field_tag    = TAG_HEADER;
        res.status       = ST_OK;
        res.byte_out     = i_byte;
        in_header        = r_pos < POS_W'(HEADER_LEN);
        limit            = (r_count < 8'(MAX_ENTRIES)) ? r_count : 8'(MAX_ENTRIES);
        pe_inc           = {1'b0, r_pe} + 1'b1;
        k                = '0;
        num_base         = '0;

        if (in_header) begin
            if (r_pos == POS_W'(0)) begin
                n_version = i_byte;
            end else if (r_pos == POS_W'(1)) begin
                n_count = i_byte;
            end else begin
                n_stored_crc = r_stored_crc | ({24'd0, i_byte} << {r_pos[1:0] - 2'd2, 3'b000});
            end
            res.field_end = (r_pos == POS_W'(HEADER_LEN - 1));
        end else begin
            n_crc = crc_upd;
            if (8'(r_entry) < limit) begin
                res.entry_index = r_entry[3:0];
                if (r_pe < PE_W'(STR3_END)) begin
                    if (r_pe < PE_W'(STR1_END)) begin
                        res.field_tag = TAG_ID;
                        res.field_end = (pe_inc == (PE_W+1)'(STR1_END));
                    end else if (r_pe < PE_W'(STR2_END)) begin
                        res.field_tag = TAG_SYMBOL;
                        res.field_end = (pe_inc == (PE_W+1)'(STR2_END));
                    end else begin
                        res.field_tag = TAG_NAME;
                        res.field_end = (pe_inc == (PE_W+1)'(STR3_END));
                    end
                    if (res.field_end) begin
                        res.byte_out = '0;
                    end
                end else if (r_pe == PE_W'(STR3_END)) begin
                    res.field_tag = TAG_SOURCE;
                    res.field_end = 1'b1;
                    if ((i_byte < 8'd1 || i_byte > 8'd2) && r_code_err == ST_OK) begin
                        n_code_err = ST_SOURCE;
                    end
                end else if (r_pe == PE_W'(STR3_END + 1)) begin
                    res.field_tag = TAG_KIND;
                    res.field_end = 1'b1;
                    if ((i_byte < 8'd1 || i_byte > 8'd4) && r_code_err == ST_OK) begin
                        n_code_err = ST_KIND;
                    end
                end else if (r_pe == PE_W'(STR3_END + 2)) begin
                    res.field_tag = TAG_BASIS;
                    res.field_end = 1'b1;
                    if ((i_byte < 8'd1 || i_byte > 8'd2) && r_code_err == ST_OK) begin
                        n_code_err = ST_BASIS;
                    end
                end else begin
                    if (r_pe < PE_W'(STR3_END + 5)) begin
                        res.field_tag = TAG_CADENCE;
                        k = 2'(r_pe - PE_W'(STR3_END + 3));
                        res.field_end = (k == 2'd1);
                    end else begin
                        res.field_tag = TAG_STALE;
                        k = 2'(r_pe - PE_W'(STR3_END + 5));
                        res.field_end = (k == 2'd3);
                    end
                    num_base = (k == 2'd0) ? 32'd0 : r_num;
                    n_num    = num_base | ({24'd0, i_byte} << {k, 3'b000});
                    if (res.field_end) begin
                        res.number_value = n_num;
                    end
                end
                if (pe_inc >= (PE_W+1)'(ENTRY_LEN)) begin
                    n_pe    = '0;
                    n_entry = r_entry + 1'b1;
                end else begin
                    n_pe = pe_inc[PE_W-1:0];
                end
            end else begin
                res.field_tag = TAG_EXCESS;
            end
        end

        exp_len = 16'(HEADER_LEN) + 16'(n_count) * 16'(ENTRY_LEN);
        got_len = 16'(r_pos) + 16'd1;

        if (i_last) begin
            res.blob_done = 1'b1;
            if (r_pos < POS_W'(HEADER_LEN - 1)) begin
                res.status = ST_SHORT;
            end else if (n_version != i_exp_version) begin
                res.status = ST_VERSION;
            end else if (n_count < 8'd1 || n_count > 8'(MAX_ENTRIES)
                         || n_count > {3'd0, i_max_entries}) begin
                res.status = ST_COUNT;
            end else if (r_pos >= POS_SAT || got_len != exp_len) begin
                res.status = ST_LENGTH;
            end else if ((n_crc ^ CRC_INIT) != n_stored_crc) begin
                res.status = ST_CRC;
            end else begin
                res.status = n_code_err;
            end
            if (res.status == ST_OK) begin
                res.entry_count = n_count[4:0];
            end
            n_crc        = CRC_INIT;
            n_stored_crc = '0;
            n_pos        = '0;
            n_pe         = '0;
            n_entry      = '0;
            n_count      = '0;
            n_version    = '0;
            n_code_err   = ST_OK;
            n_num        = '0;
        end
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_stored_crc <= '0;
            r_pos        <= '0;
            r_pe         <= '0;
            r_entry      <= '0;
            r_count      <= '0;
            r_version    <= '0;
            r_code_err   <= ST_OK;
            r_num        <= '0;
        end else if (i_fire) begin
            r_crc        <= n_crc;
            r_stored_crc <= n_stored_crc;
            r_pos        <= n_pos;
            r_pe         <= n_pe;
            r_entry      <= n_entry;
            r_count      <= n_count;
            r_version    <= n_version;
            r_code_err   <= n_code_err;
            r_num        <= n_num;
        end
    end

endmodule

### rtl/record_blob_validator_crc32_unit.sv
`timescale 1ns / 1ps
// Top level: input word register, blob parser, result register, config registers.
// Depends on rbv_pkg, rbv_blob_if, rbv_rec_if and rbv_parser.
//
//   channel   dir  words                         handshake
//   i_blob    in   blob_byte, last_byte          valid/ready
//   o_rec     out  one tagged result per byte    valid/ready
//   i_cfg_*   in   expected_version, max_entries write enable, no ready
//
// One word per cycle sustained while o_rec is not stalled; a byte is taken into the
// input register, then its result goes through the parse logic into the result register.
// Synchronous active-low reset empties the pipeline, clears the blob state and loads
// the config defaults.
// A stalled output holds both stages; the input stays ready while the input
// register is empty or moving.
module record_blob_validator_crc32_unit
    import rbv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbv_blob_if.sink              i_blob,
    rbv_rec_if.source             o_rec,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_res;
    t_result    parse_res;
    logic [7:0] r_exp_version;
    logic [4:0] r_max_entries;
    logic       advance;
    logic       fire;

    assign advance      = !r_out_valid || o_rec.ready;
    assign fire         = r_in_valid && advance;
    assign i_blob.ready = !r_in_valid || advance;

    rbv_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_byte        (r_in_byte),
        .i_last        (r_in_last),
        .i_exp_version (r_exp_version),
        .i_max_entries (r_max_entries),
        .o_res         (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_blob.ready) begin
                r_in_valid <= i_blob.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (i_blob.valid && i_blob.ready) begin
            r_in_byte <= i_blob.blob_byte;
            r_in_last <= i_blob.last_byte;
        end
        if (fire) begin
            r_res <= parse_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= RST_EXP_VERSION;
            r_max_entries <= RST_MAX_ENTRIES;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EXP_VERSION: r_exp_version <= i_cfg_data[7:0];
                CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign o_rec.valid        = r_out_valid;
    assign o_rec.entry_index  = r_res.entry_index;
    assign o_rec.field_tag    = r_res.field_tag;
    assign o_rec.byte_out     = r_res.byte_out;
    assign o_rec.field_end    = r_res.field_end;
    assign o_rec.number_value = r_res.number_value;
    assign o_rec.blob_done    = r_res.blob_done;
    assign o_rec.status       = r_res.status;
    assign o_rec.entry_count  = r_res.entry_count;

endmodule

### sim/rbv_echo_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the record blob validator: mirrors the header, entry and CRC state,
// predicts the tagged echo of every accepted word and compares the results in order.
// Depends on rbv_pkg, rbv_blob_if and rbv_rec_if.
module rbv_echo_checker
    import rbv_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rbv_blob_if                   i_blob,
    rbv_rec_if                    i_rec,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    logic [7:0]  want_version;
    logic [4:0]  want_max;
    logic [31:0] crc_run;
    logic [31:0] crc_hdr;
    logic [11:0] byte_pos;
    logic [6:0]  entry_pos;
    logic [4:0]  entry_num;
    logic [7:0]  count_hdr;
    logic [7:0]  version_hdr;
    t_status     code_fault;
    logic [31:0] num_acc;
    t_result     pending_echo[$];
    int          fail_n;

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void restart_blob();
        crc_run     = CRC_INIT;
        crc_hdr     = '0;
        byte_pos    = '0;
        entry_pos   = '0;
        entry_num   = '0;
        count_hdr   = '0;
        version_hdr = '0;
        code_fault  = ST_OK;
        num_acc     = '0;
    endfunction

    function automatic void note_fault(input t_status st);
        if (code_fault == ST_OK)
            code_fault = st;
    endfunction

    function automatic t_result predict_echo(input logic [7:0] b, input logic fin);
        t_result r;
        int      pos;
        int      pe;
        int      lim;
        int      k;
        r = '0;
        r.field_tag = TAG_HEADER;
        r.status = ST_OK;
        r.byte_out = b;
        pos = int'(byte_pos);
        if (pos < HEADER_LEN) begin
            if (pos == 0)
                version_hdr = b;
            else if (pos == 1)
                count_hdr = b;
            else
                crc_hdr[8*(pos-2) +: 8] = b;
            r.field_end = (pos == HEADER_LEN - 1);
        end else begin
            crc_run = crc_fold(crc_run, b);
            lim = (count_hdr < MAX_ENTRIES) ? int'(count_hdr) : MAX_ENTRIES;
            if (int'(entry_num) < lim) begin
                pe = int'(entry_pos);
                r.entry_index = entry_num[3:0];
                if (pe < STR3_END) begin
                    r.field_tag = (pe < STR1_END) ? TAG_ID :
                                  (pe < STR2_END) ? TAG_SYMBOL : TAG_NAME;
                    if (pe + 1 == STR1_END || pe + 1 == STR2_END || pe + 1 == STR3_END) begin
                        r.byte_out = '0;
                        r.field_end = 1'b1;
                    end
                end else if (pe == STR3_END) begin
                    r.field_tag = TAG_SOURCE;
                    r.field_end = 1'b1;
                    if (b < 1 || b > 2)
                        note_fault(ST_SOURCE);
                end else if (pe == STR3_END + 1) begin
                    r.field_tag = TAG_KIND;
                    r.field_end = 1'b1;
                    if (b < 1 || b > 4)
                        note_fault(ST_KIND);
                end else if (pe == STR3_END + 2) begin
                    r.field_tag = TAG_BASIS;
                    r.field_end = 1'b1;
                    if (b < 1 || b > 2)
                        note_fault(ST_BASIS);
                end else begin
                    k = (pe < STR3_END + 5) ? pe - (STR3_END + 3) : pe - (STR3_END + 5);
                    r.field_tag = (pe < STR3_END + 5) ? TAG_CADENCE : TAG_STALE;
                    if (k == 0)
                        num_acc = '0;
                    num_acc[8*k +: 8] = b;
                    if ((r.field_tag == TAG_CADENCE && k == 1) ||
                        (r.field_tag == TAG_STALE && k == 3)) begin
                        r.field_end = 1'b1;
                        r.number_value = num_acc;
                    end
                end
                if (pe == ENTRY_LEN - 1) begin
                    entry_pos = '0;
                    entry_num = entry_num + 5'd1;
                end else begin
                    entry_pos = 7'(pe + 1);
                end
            end else begin
                r.field_tag = TAG_EXCESS;
            end
        end
        if (byte_pos != POS_SAT)
            byte_pos = byte_pos + 12'd1;
        if (fin) begin
            r.blob_done = 1'b1;
            if (pos < HEADER_LEN - 1)
                r.status = ST_SHORT;
            else if (version_hdr != want_version)
                r.status = ST_VERSION;
            else if (count_hdr < 1 || count_hdr > MAX_ENTRIES || count_hdr > want_max)
                r.status = ST_COUNT;
            else if (pos >= int'(POS_SAT) ||
                     pos + 1 != HEADER_LEN + int'(count_hdr) * ENTRY_LEN)
                r.status = ST_LENGTH;
            else if ((crc_run ^ CRC_INIT) != crc_hdr)
                r.status = ST_CRC;
            else
                r.status = code_fault;
            if (r.status == ST_OK)
                r.entry_count = count_hdr[4:0];
            restart_blob();
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            want_version = RST_EXP_VERSION;
            want_max = RST_MAX_ENTRIES;
            restart_blob();
            pending_echo.delete();
            fail_n = 0;
        end else begin
            if (i_rec.valid && i_rec.ready) begin
                got.entry_index  = i_rec.entry_index;
                got.field_tag    = t_tag'(i_rec.field_tag);
                got.byte_out     = i_rec.byte_out;
                got.field_end    = i_rec.field_end;
                got.number_value = i_rec.number_value;
                got.blob_done    = i_rec.blob_done;
                got.status       = t_status'(i_rec.status);
                got.entry_count  = i_rec.entry_count;
                if (pending_echo.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: result word with nothing outstanding", $time);
                end else begin
                    want = pending_echo.pop_front();
                    if (got !== want) begin
                        fail_n++;
                        if (fail_n <= 10) begin
                            $write("%0t: echo mismatch (expected/actual) index %0d/%0d",
                                   $time, want.entry_index, got.entry_index);
                            $write(" tag %0d/%0d byte %02h/%02h end %0b/%0b",
                                   want.field_tag, got.field_tag, want.byte_out,
                                   got.byte_out, want.field_end, got.field_end);
                            $write(" number %08h/%08h done %0b/%0b",
                                   want.number_value, got.number_value,
                                   want.blob_done, got.blob_done);
                            $display(" status %0d/%0d count %0d/%0d",
                                     want.status, got.status,
                                     want.entry_count, got.entry_count);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_EXP_VERSION: want_version = i_cfg_data[7:0];
                    CFG_MAX_ENTRIES: want_max = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_blob.valid && i_blob.ready)
                pending_echo.push_back(predict_echo(i_blob.blob_byte, i_blob.last_byte));
        end
        o_pending <= pending_echo.size();
        o_mismatches <= fail_n;
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for record_blob_validator_crc32_unit: builds blobs (clean, corrupt and
// noise), drives them with random gaps and output stalls, and gives the verdict.
// Depends on rbv_pkg, rbv_blob_if, rbv_rec_if, rbv_echo_checker and the block itself.
module tb_top;
    import rbv_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {F_NONE, F_CODE, F_EXTRA, F_SHORT} t_fault;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  sink_ready = 1'b1;
    logic                  stall_on = 1'b0;
    int                    stall_left = 0;
    int                    wd_count = 0;
    int                    mismatch_n;
    int                    pending_n;
    bit                    idle_on;
    int                    bytes_sent;
    logic [7:0]            cur_version;
    int                    cur_max;
    logic [7:0]            blob_q[$];

    rbv_blob_if blob_ch();
    rbv_rec_if  rec_ch();

    assign rec_ch.ready = sink_ready;

    record_blob_validator_crc32_unit uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_blob     (blob_ch),
        .o_rec      (rec_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rbv_echo_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_blob       (blob_ch),
        .i_rec        (rec_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatch_n),
        .o_pending    (pending_n)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 6) == 0) begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (blob_ch.valid && blob_ch.ready) || (rec_ch.valid && rec_ch.ready)) begin
            wd_count <= 0;
        end else if (wd_count == WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            wd_count <= wd_count + 1;
        end
    end

    function automatic logic [31:0] crc_advance(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // hold the sender until every word in flight has come out
    task automatic settle();
        blob_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_n != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [7:0] ver, input int maxe);
        logic [2:0] hi;
        logic [4:0] lo;
        hi = 3'($urandom_range(0, 7));
        lo = 5'(maxe);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_EXP_VERSION;
        cfg_data <= ver;
        @(posedge clk);
        cfg_idx <= CFG_MAX_ENTRIES;
        cfg_data <= {hi, lo};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_version = ver;
        cur_max = maxe;
    endtask

    task automatic make_blob(input int n_ent, input int hdr_cnt, input logic [7:0] ver,
                             input t_fault flt, input bit crc_bad);
        logic [7:0]  body[$];
        logic [31:0] crc;
        int          fld;
        int          fill;
        int          off;
        int          cut;
        for (int e = 0; e < n_ent; e++) begin
            for (int s = 0; s < 3; s++) begin
                fld = (s == 0) ? ID_BYTES : (s == 1) ? SYMBOL_BYTES : NAME_BYTES;
                fill = $urandom_range(0, fld);
                for (int j = 0; j < fld; j++)
                    body.push_back(j < fill ? 8'($urandom) : 8'h00);
            end
            body.push_back(8'($urandom_range(1, 2)));
            body.push_back(8'($urandom_range(1, 4)));
            body.push_back(8'($urandom_range(1, 2)));
            repeat (6) body.push_back(8'($urandom));
        end
        if (flt == F_CODE && n_ent > 0) begin
            repeat ($urandom_range(1, 2)) begin
                fld = $urandom_range(0, 2);
                off = $urandom_range(0, n_ent - 1) * ENTRY_LEN + STR3_END + fld;
                body[off] = $urandom_range(0, 1) ? 8'h00 :
                            8'($urandom_range(fld == 1 ? 5 : 3, 255));
            end
        end
        crc = CRC_INIT;
        foreach (body[i])
            crc = crc_advance(crc, body[i]);
        crc = crc ^ CRC_INIT;
        if (crc_bad)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        blob_q.delete();
        blob_q.push_back(ver);
        blob_q.push_back(8'(hdr_cnt));
        for (int i = 0; i < 4; i++)
            blob_q.push_back(crc[8*i +: 8]);
        foreach (body[i])
            blob_q.push_back(body[i]);
        if (flt == F_EXTRA)
            repeat ($urandom_range(1, 20)) blob_q.push_back(8'($urandom));
        if (flt == F_SHORT) begin
            cut = $urandom_range(0, 1) ? $urandom_range(1, HEADER_LEN - 1) :
                  $urandom_range(HEADER_LEN, blob_q.size() - 1);
            while (blob_q.size() > cut)
                void'(blob_q.pop_back());
        end
    endtask

    task automatic random_blob();
        int pick;
        int n_ent;
        int bad_cnt;
        bit crc_bad;
        pick = $urandom_range(0, 99);
        n_ent = (cur_max > 1 && $urandom_range(0, 3) == 0) ? 2 : 1;
        crc_bad = ($urandom_range(0, 3) == 0);
        if (pick < 55) begin
            make_blob(n_ent, n_ent, cur_version, F_NONE, 1'b0);
        end else if (pick < 64) begin
            make_blob(n_ent, n_ent, cur_version, F_CODE, crc_bad);
        end else if (pick < 70) begin
            make_blob(n_ent, n_ent, cur_version, F_NONE, 1'b1);
        end else if (pick < 75) begin
            make_blob(n_ent, n_ent, cur_version + 8'($urandom_range(1, 255)), F_NONE, crc_bad);
        end else if (pick < 80) begin
            case ($urandom_range(0, 2))
                0: bad_cnt = 0;
                1: bad_cnt = (cur_max < MAX_ENTRIES) ? $urandom_range(cur_max + 1, MAX_ENTRIES)
                                                      : $urandom_range(MAX_ENTRIES + 1, 255);
                default: bad_cnt = $urandom_range(MAX_ENTRIES + 1, 255);
            endcase
            make_blob(1, bad_cnt, cur_version, F_NONE, crc_bad);
        end else if (pick < 86) begin
            if ($urandom_range(0, 1))
                make_blob(n_ent + 1, n_ent, cur_version, F_NONE, crc_bad);
            else if (n_ent < cur_max)
                make_blob(n_ent, n_ent + 1, cur_version, F_NONE, crc_bad);
            else
                make_blob(n_ent, n_ent, cur_version, F_SHORT, crc_bad);
        end else if (pick < 91) begin
            make_blob(n_ent, n_ent, cur_version, F_EXTRA, 1'b0);
        end else if (pick < 95) begin
            make_blob(n_ent, n_ent, cur_version, F_SHORT, crc_bad);
        end else begin
            blob_q.delete();
            repeat ($urandom_range(1, 40)) blob_q.push_back(8'($urandom));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            blob_ch.valid <= 1'b0;
            blob_ch.blob_byte <= 8'($urandom);
            blob_ch.last_byte <= 1'($urandom);
            repeat (gap) @(posedge clk);
        end
        blob_ch.valid <= 1'b1;
        blob_ch.blob_byte <= b;
        blob_ch.last_byte <= fin;
        @(posedge clk);
        while (!blob_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_blob(input int pause_at);
        for (int i = 0; i < blob_q.size(); i++) begin
            if (i == pause_at)
                settle();
            send_byte(blob_q[i], i == blob_q.size() - 1);
        end
    endtask

    task automatic run_phase(input int min_bytes, input bit quiet);
        int start;
        int blobs;
        int pause_blob;
        start = bytes_sent;
        blobs = 0;
        pause_blob = $urandom_range(0, 1);
        while (bytes_sent - start < min_bytes || blobs < 2) begin
            idle_on = !quiet && ($urandom_range(0, 3) != 0);
            stall_on <= !quiet && ($urandom_range(0, 3) != 0);
            random_blob();
            send_blob((blobs == pause_blob && blob_q.size() > 1) ?
                      $urandom_range(1, blob_q.size() - 1) : -1);
            blobs++;
        end
        settle();
    endtask

    initial begin
        blob_ch.valid <= 1'b0;
        blob_ch.blob_byte <= 8'h00;
        blob_ch.last_byte <= 1'b0;
        cfg_we <= 1'b0;
        cfg_idx <= CFG_EXP_VERSION;
        cfg_data <= '0;
        rst_n <= 1'b0;
        cur_version = RST_EXP_VERSION;
        cur_max = RST_MAX_ENTRIES;
        bytes_sent = 0;
        idle_on = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        stall_on <= 1'b1;
        @(posedge clk);

        // header-only and truncated blobs under the reset settings
        blob_q.delete();
        blob_q.push_back(8'hFF);
        send_blob(-1);
        make_blob(0, 1, cur_version, F_NONE, 1'b0);
        void'(blob_q.pop_back());
        send_blob(-1);
        make_blob(0, 1, cur_version, F_NONE, 1'b0);
        send_blob(2);
        make_blob(0, 0, cur_version, F_NONE, 1'b0);
        send_blob(-1);
        make_blob(0, 8'hFF, cur_version, F_NONE, 1'b0);
        send_blob(-1);
        make_blob(0, 1, 8'hFF, F_NONE, 1'b0);
        send_blob(-1);
        settle();

        write_config(8'h00, 1);
        run_phase(110, 1'b0);

        write_config(8'hFF, MAX_ENTRIES);
        run_phase(110, 1'b0);

        write_config(8'($urandom), $urandom_range(2, MAX_ENTRIES - 1));
        run_phase(110, 1'b0);

        write_config(8'($urandom), $urandom_range(1, MAX_ENTRIES));
        run_phase(110, 1'b1);

        settle();
        if (mismatch_n == 0 && pending_n == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### filelist.f
rtl/rbv_pkg.sv
rtl/rbv_blob_if.sv
rtl/rbv_rec_if.sv
rtl/rbv_crc_byte.sv
rtl/rbv_parser.sv
rtl/record_blob_validator_crc32_unit.sv
sim/rbv_echo_checker.sv
sim/tb_top.sv
